FILE: rtl/multichannel_pulse_train_generator_assert.svh
// Assertion macros for the pulse train generator
`ifndef MULTICHANNEL_PULSE_TRAIN_GENERATOR_ASSERT_SVH
`define MULTICHANNEL_PULSE_TRAIN_GENERATOR_ASSERT_SVH

// Check a property outside reset
`define MPTG_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("mptg check failed");

// Check a property at every edge, reset included
`define MPTG_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("mptg check failed");

`endif

FILE: rtl/mptg_pkg.sv
// Types and constants shared by the pulse train generator modules
package mptg_pkg;

    localparam int MAX_OUT = 8;
    localparam int NRES_W  = 4;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    localparam logic KIND_PIN = 1'b0;
    localparam logic KIND_RSP = 1'b1;

    localparam logic [15:0] TICK_RESET = 16'd10;

    typedef struct packed {
        logic [15:0]        count;
        logic signed [25:0] phase;
        logic [23:0]        period;
        logic [23:0]        width;
        logic [7:0]         pin;
    } t_slot_entry;

    typedef struct packed {
        logic keep;
        logic emit;
        logic level;
    } t_upd_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START_RSP,
        ST_TICK,
        ST_TICK_END,
        ST_TICK_FLUSH
    } t_state;

    typedef struct packed {
        logic busy;
        logic rd_en;
        logic send_rsp;
        logic flush;
    } t_ctrl;

endpackage

FILE: rtl/mptg_slot_mem.sv
// Slot table memory: one write port, one registered read port
module mptg_slot_mem #(
    parameter int SLOTS = 8,
    parameter int AW    = 3
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  mptg_pkg::t_slot_entry i_wdata,
    input  logic                  i_re,
    input  logic [AW-1:0]         i_raddr,
    output mptg_pkg::t_slot_entry o_rdata
);

    mptg_pkg::t_slot_entry r_mem [SLOTS];
    mptg_pkg::t_slot_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/mptg_slot_upd.sv
// Per-slot tick update: advance phase, wrap, count down, pick pin level
module mptg_slot_upd (
    input  mptg_pkg::t_slot_entry i_entry,
    input  logic [15:0]           i_tick,
    output mptg_pkg::t_slot_entry o_entry,
    output mptg_pkg::t_upd_res    o_res
);

    logic signed [25:0] ph_sum;
    logic signed [25:0] ph_new;
    logic signed [25:0] per;
    logic signed [25:0] w_lo;
    logic signed [25:0] w_hi;
    logic               wrap;
    logic [15:0]        cnt_new;
    logic               lvl_hi;
    logic               lvl_lo;

    always_comb begin
        ph_sum  = i_entry.phase + $signed({10'b0, i_tick});
        per     = $signed({2'b0, i_entry.period});
        w_lo    = $signed({2'b0, i_entry.width});
        w_hi    = w_lo + $signed({10'b0, i_tick});
        wrap    = (ph_sum >= per);
        ph_new  = wrap ? 26'sd0 : ph_sum;
        cnt_new = wrap ? (i_entry.count - 16'd1) : i_entry.count;
        lvl_hi  = (ph_new == 26'sd0);
        lvl_lo  = !lvl_hi && (ph_new >= w_lo) && (ph_new < w_hi);

        o_entry       = i_entry;
        o_entry.phase = ph_new;
        o_entry.count = cnt_new;

        o_res.keep  = (cnt_new != 16'd0);
        o_res.emit  = o_res.keep && (lvl_hi || lvl_lo);
        o_res.level = lvl_hi;
    end

endmodule

FILE: rtl/multichannel_pulse_train_generator.sv
// Pulse train generator top level: control, slot table walk and result register
//
// Items enter on start while busy is low. i_operation selects a tick or a start.
// A start claims the lowest free slot. When claimed, a pin-low write leaves in
// the cycle after the transfer and the accepted response the cycle after; busy is
// high for one cycle. When refused, one response leaves in the next cycle and the
// block is ready again at once.
// A tick walks the slot table, one slot per cycle through the registered read
// port, and writes each active slot back. Busy stays high through the walk and
// the TICK_END and TICK_FLUSH states. Each pin write is held in a pending
// register until the next one is found or the walk ends; the final one carries
// o_last and shows as busy falls.
// Each result shows for one cycle with o_strobe; the receiver cannot stall.
// The tick interval register is written over the cfg channel while idle.
// Reset frees every slot at once and sets the tick interval to 10.
module multichannel_pulse_train_generator #(
    parameter int SLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_operation,
    input  logic [7:0]  i_pin_id,
    input  logic [23:0] i_period_us,
    input  logic [23:0] i_width_us,
    input  logic [15:0] i_pulse_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    output logic        o_strobe,
    output logic        o_result_kind,
    output logic [7:0]  o_out_pin,
    output logic        o_level,
    output logic        o_accepted,
    output logic [5:0]  o_slot_index,
    output logic        o_last
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    mptg_pkg::t_state r_state;
    mptg_pkg::t_state n_state;
    mptg_pkg::t_ctrl  ctrl;

    logic [15:0]      r_tick;
    logic [SLOTS-1:0] r_active;
    logic [AW-1:0]    r_addr;
    logic             r_s1_vld;
    logic [AW-1:0]    r_s1_addr;
    logic             r_s1_act;
    logic [mptg_pkg::NRES_W-1:0] r_nres;

    logic        r_pend_vld;
    logic [7:0]  r_pend_pin;
    logic        r_pend_level;
    logic [5:0]  r_pend_slot;

    logic [7:0]  r_req_pin;
    logic [5:0]  r_req_slot;

    logic        r_strobe;
    logic        r_kind;
    logic [7:0]  r_pin;
    logic        r_level;
    logic        r_acc;
    logic [5:0]  r_slot;
    logic        r_last;

    logic          acc_item;
    logic          acc_start;
    logic          acc_tick;
    logic          free_ok;
    logic [AW-1:0] free_idx;
    logic          last_addr;
    logic          take_res;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    mptg_pkg::t_slot_entry mem_wdata;
    mptg_pkg::t_slot_entry mem_rdata;
    mptg_pkg::t_slot_entry start_entry;
    mptg_pkg::t_slot_entry upd_entry;
    mptg_pkg::t_upd_res    upd_res;

    function automatic logic [AW-1:0] first_free(input logic [SLOTS-1:0] act);
        logic [AW-1:0] idx;
        idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!act[i]) begin
                idx = AW'(i);
            end
        end
        return idx;
    endfunction

    assign acc_item  = start && !ctrl.busy;
    assign acc_start = acc_item && (i_operation == mptg_pkg::OP_START);
    assign acc_tick  = acc_item && (i_operation == mptg_pkg::OP_TICK);
    assign free_ok   = !(&r_active);
    assign free_idx  = first_free(r_active);
    assign last_addr = (r_addr == AW'(SLOTS - 1));
    assign take_res  = r_s1_vld && r_s1_act && upd_res.emit
                       && (r_nres < mptg_pkg::NRES_W'(mptg_pkg::MAX_OUT));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mptg_pkg::ST_IDLE: begin
                if (acc_start && free_ok) begin
                    n_state = mptg_pkg::ST_START_RSP;
                end else if (acc_tick) begin
                    n_state = mptg_pkg::ST_TICK;
                end
            end
            mptg_pkg::ST_START_RSP: n_state = mptg_pkg::ST_IDLE;
            mptg_pkg::ST_TICK: begin
                if (last_addr) begin
                    n_state = mptg_pkg::ST_TICK_END;
                end
            end
            mptg_pkg::ST_TICK_END:   n_state = mptg_pkg::ST_TICK_FLUSH;
            mptg_pkg::ST_TICK_FLUSH: n_state = mptg_pkg::ST_IDLE;
            default:                 n_state = mptg_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl.busy     = (r_state != mptg_pkg::ST_IDLE);
        ctrl.rd_en    = (r_state == mptg_pkg::ST_TICK);
        ctrl.send_rsp = (r_state == mptg_pkg::ST_START_RSP);
        ctrl.flush    = (r_state == mptg_pkg::ST_TICK_FLUSH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mptg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        start_entry.count  = i_pulse_count;
        start_entry.phase  = $signed(26'd0 - {10'b0, r_tick});
        start_entry.period = i_period_us;
        start_entry.width  = i_width_us;
        start_entry.pin    = i_pin_id;
    end

    assign mem_we    = (acc_start && free_ok) || (r_s1_vld && r_s1_act);
    assign mem_waddr = r_s1_vld ? r_s1_addr : free_idx;
    assign mem_wdata = r_s1_vld ? upd_entry : start_entry;

    mptg_slot_mem #(
        .SLOTS (SLOTS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (ctrl.rd_en),
        .i_raddr (r_addr),
        .o_rdata (mem_rdata)
    );

    mptg_slot_upd u_upd (
        .i_entry (mem_rdata),
        .i_tick  (r_tick),
        .o_entry (upd_entry),
        .o_res   (upd_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick     <= mptg_pkg::TICK_RESET;
            r_active   <= '0;
            r_addr     <= '0;
            r_s1_vld   <= 1'b0;
            r_s1_act   <= 1'b0;
            r_nres     <= '0;
            r_pend_vld <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_s1_vld <= ctrl.rd_en;
            r_s1_act <= r_active[r_addr];

            if (i_cfg_valid && o_cfg_ready) begin
                r_tick <= i_cfg_data;
            end

            if (acc_start && free_ok) begin
                r_active[free_idx] <= (i_pulse_count != 16'd0);
            end
            if (r_s1_vld && r_s1_act) begin
                r_active[r_s1_addr] <= upd_res.keep;
            end

            if (acc_tick) begin
                r_addr     <= '0;
                r_nres     <= '0;
                r_pend_vld <= 1'b0;
            end else if (ctrl.rd_en && !last_addr) begin
                r_addr <= r_addr + AW'(1);
            end

            if (take_res) begin
                r_pend_vld <= 1'b1;
                r_nres     <= r_nres + mptg_pkg::NRES_W'(1);
            end
            if (ctrl.flush) begin
                r_pend_vld <= 1'b0;
            end

            priority if (acc_start) begin
                r_strobe <= 1'b1;
            end else if (ctrl.send_rsp) begin
                r_strobe <= 1'b1;
            end else if (take_res && r_pend_vld) begin
                r_strobe <= 1'b1;
            end else if (ctrl.flush && r_pend_vld) begin
                r_strobe <= 1'b1;
            end else begin
                r_strobe <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_addr <= r_addr;

        if (acc_start) begin
            r_req_pin  <= i_pin_id;
            r_req_slot <= 6'(free_idx);
        end

        if (take_res) begin
            r_pend_pin   <= upd_entry.pin;
            r_pend_level <= upd_res.level;
            r_pend_slot  <= 6'(r_s1_addr);
        end

        priority if (acc_start) begin
            r_pin   <= i_pin_id;
            r_level <= 1'b0;
            if (free_ok) begin
                r_kind <= mptg_pkg::KIND_PIN;
                r_acc  <= 1'b0;
                r_slot <= 6'(free_idx);
                r_last <= 1'b0;
            end else begin
                r_kind <= mptg_pkg::KIND_RSP;
                r_acc  <= 1'b0;
                r_slot <= 6'd0;
                r_last <= 1'b1;
            end
        end else if (ctrl.send_rsp) begin
            r_kind  <= mptg_pkg::KIND_RSP;
            r_pin   <= r_req_pin;
            r_level <= 1'b0;
            r_acc   <= 1'b1;
            r_slot  <= r_req_slot;
            r_last  <= 1'b1;
        end else if ((take_res || ctrl.flush) && r_pend_vld) begin
            r_kind  <= mptg_pkg::KIND_PIN;
            r_pin   <= r_pend_pin;
            r_level <= r_pend_level;
            r_acc   <= 1'b0;
            r_slot  <= r_pend_slot;
            r_last  <= ctrl.flush;
        end else begin
            // hold the result registers
        end
    end

    assign busy          = ctrl.busy;
    assign o_cfg_ready   = !ctrl.busy;
    assign o_strobe      = r_strobe;
    assign o_result_kind = r_kind;
    assign o_out_pin     = r_pin;
    assign o_level       = r_level;
    assign o_accepted    = r_acc;
    assign o_slot_index  = r_slot;
    assign o_last        = r_last;

`include "multichannel_pulse_train_generator_assert.svh"

    `MPTG_ASSERT(a_rsp_is_last, i_clk, i_rst_n, (o_strobe && o_result_kind == mptg_pkg::KIND_RSP) |-> o_last)
    `MPTG_ASSERT(a_claim_pin_first, i_clk, i_rst_n, (r_state == mptg_pkg::ST_START_RSP) |-> (o_strobe && o_result_kind == mptg_pkg::KIND_PIN && !o_last))
    `MPTG_ASSERT(a_tick_holds_busy, i_clk, i_rst_n, (acc_tick) |=> (busy && r_addr == '0 && !r_pend_vld))
    `MPTG_ASSERT(a_result_bound, i_clk, i_rst_n, r_nres <= mptg_pkg::NRES_W'(mptg_pkg::MAX_OUT))

endmodule
